[design/rcp_pkg.sv]
// rcp_pkg: shared types and constants for the RGB cross-fade PWM block.
// No dependencies; imported by rcp_fade, rgb_crossfade_pwm_top and tb.
package rcp_pkg;

  localparam int DUTY_W          = 8;
  localparam int REG_W           = 8;
  localparam int APB_DW          = 32;
  localparam int APB_AW          = 4;
  localparam int COUNT_WIDTH_DEF = 8;

  localparam logic [REG_W-1:0] PWM_PERIOD_RST     = 8'd100;
  localparam logic [REG_W-1:0] TICKS_PER_BASE_RST = 8'd100;
  localparam logic [REG_W-1:0] BASES_PER_STEP_RST = 8'd10;
  localparam logic [REG_W-1:0] MAX_DUTY_RST       = 8'd100;

  typedef enum logic [1:0] {
    REG_PWM_PERIOD     = 2'd0,
    REG_TICKS_PER_BASE = 2'd1,
    REG_BASES_PER_STEP = 2'd2,
    REG_MAX_DUTY       = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    PH_RED   = 2'd0,
    PH_GREEN = 2'd1,
    PH_BLUE  = 2'd2
  } phase_t;

  typedef struct packed {
    logic              step;
    logic [REG_W-1:0]  max_duty;
  } fade_ctrl_t;

  typedef struct packed {
    logic [DUTY_W-1:0] red;
    logic [DUTY_W-1:0] green;
    logic [DUTY_W-1:0] blue;
    phase_t            phase;
  } fade_state_t;

endpackage

[design/rgb_crossfade_pwm_top.sv]
// rgb_crossfade_pwm_top: three-channel software PWM with RGB cross-fade,
// APB register block and valid/ready word channels. Uses rcp_pkg, rcp_fade.
//
//   channel | ports          | word
//   --------+----------------+---------------------------------------------
//   in      | in_valid/ready | in_tick
//   out     | out_valid/ready| out_red_pin, out_green_pin, out_blue_pin,
//           |                | out_fade_phase
//   cfg     | cfg_p*         | pwm_period, ticks_per_base, bases_per_step,
//           |                | max_duty at byte addresses 0, 4, 8, 12
//
// One word per cycle while out is not stalled: counters, duties and pins update at
// the accepting edge, which loads the result word into the output registers.
// A new word is taken while the result is being taken in the same cycle.
// A stall on out holds in_ready low until the result leaves.
// Reset: pins off (high), duties, counters and phase zero, registers default.
module rgb_crossfade_pwm_top
  import rcp_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,

  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_tick,

  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_red_pin,
  output logic              out_green_pin,
  output logic              out_blue_pin,
  output logic [1:0]        out_fade_phase,

  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [APB_AW-1:0] cfg_paddr,
  input  logic [APB_DW-1:0] cfg_pwdata,
  output logic [APB_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  localparam int CMP_W = (COUNT_WIDTH > REG_W) ? COUNT_WIDTH : REG_W;

  // configuration registers
  logic [REG_W-1:0] pwm_period_r, tpb_r, bps_r, max_duty_r;
  logic             cfg_wr;
  reg_idx_t         cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pwm_period_r <= PWM_PERIOD_RST;
      tpb_r        <= TICKS_PER_BASE_RST;
      bps_r        <= BASES_PER_STEP_RST;
      max_duty_r   <= MAX_DUTY_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_PWM_PERIOD:     pwm_period_r <= cfg_pwdata[REG_W-1:0];
        REG_TICKS_PER_BASE: tpb_r        <= cfg_pwdata[REG_W-1:0];
        REG_BASES_PER_STEP: bps_r        <= cfg_pwdata[REG_W-1:0];
        REG_MAX_DUTY:       max_duty_r   <= cfg_pwdata[REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_PWM_PERIOD:     cfg_prdata = APB_DW'(pwm_period_r);
      REG_TICKS_PER_BASE: cfg_prdata = APB_DW'(tpb_r);
      REG_BASES_PER_STEP: cfg_prdata = APB_DW'(bps_r);
      REG_MAX_DUTY:       cfg_prdata = APB_DW'(max_duty_r);
      default:            cfg_prdata = '0;
    endcase
  end

  // handshake and timing counters
  logic                   out_valid_r;
  logic                   accept, tick_go;
  logic [COUNT_WIDTH-1:0] pwm_cnt_r, pwm_cnt_nxt, pwm_inc;
  logic [COUNT_WIDTH-1:0] pre_cnt_r, pre_cnt_nxt, pre_inc;
  logic [COUNT_WIDTH-1:0] stp_cnt_r, stp_cnt_nxt, stp_inc;
  logic                   base_wrap, step_wrap;
  logic                   red_pin_r, green_pin_r, blue_pin_r;
  logic                   red_pin_nxt, green_pin_nxt, blue_pin_nxt;
  fade_ctrl_t             fade_ctrl;
  fade_state_t            fade_st;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign tick_go  = accept && in_tick;

  always_comb begin
    pwm_inc   = COUNT_WIDTH'(pwm_cnt_r + 1'b1);
    pre_inc   = COUNT_WIDTH'(pre_cnt_r + 1'b1);
    stp_inc   = COUNT_WIDTH'(stp_cnt_r + 1'b1);
    // a zero limit wraps at once, so zero dividers act as one
    base_wrap = CMP_W'(pre_inc) >= CMP_W'(tpb_r);
    step_wrap = base_wrap && (CMP_W'(stp_inc) >= CMP_W'(bps_r));

    pwm_cnt_nxt = pwm_cnt_r;
    pre_cnt_nxt = pre_cnt_r;
    stp_cnt_nxt = stp_cnt_r;
    red_pin_nxt   = red_pin_r;
    green_pin_nxt = green_pin_r;
    blue_pin_nxt  = blue_pin_r;
    if (tick_go) begin
      pwm_cnt_nxt = (CMP_W'(pwm_inc) >= CMP_W'(pwm_period_r)) ? '0 : pwm_inc;
      pre_cnt_nxt = base_wrap ? '0 : pre_inc;
      if (base_wrap) stp_cnt_nxt = step_wrap ? '0 : stp_inc;
      // duties are compared before this tick's fade update
      red_pin_nxt   = !(CMP_W'(pwm_cnt_nxt) < CMP_W'(fade_st.red));
      green_pin_nxt = !(CMP_W'(pwm_cnt_nxt) < CMP_W'(fade_st.green));
      blue_pin_nxt  = !(CMP_W'(pwm_cnt_nxt) < CMP_W'(fade_st.blue));
    end
  end

  assign fade_ctrl.step     = tick_go && step_wrap;
  assign fade_ctrl.max_duty = max_duty_r;

  rcp_fade u_fade (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (fade_ctrl),
    .state (fade_st)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pwm_cnt_r   <= '0;
      pre_cnt_r   <= '0;
      stp_cnt_r   <= '0;
      red_pin_r   <= 1'b1;
      green_pin_r <= 1'b1;
      blue_pin_r  <= 1'b1;
    end else begin
      if (accept) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      pwm_cnt_r   <= pwm_cnt_nxt;
      pre_cnt_r   <= pre_cnt_nxt;
      stp_cnt_r   <= stp_cnt_nxt;
      red_pin_r   <= red_pin_nxt;
      green_pin_r <= green_pin_nxt;
      blue_pin_r  <= blue_pin_nxt;
    end
  end

  // phase register only moves on an accepted word, so it is the result field
  assign out_valid      = out_valid_r;
  assign out_red_pin    = red_pin_r;
  assign out_green_pin  = green_pin_r;
  assign out_blue_pin   = blue_pin_r;
  assign out_fade_phase = fade_st.phase;

`ifndef SYNTH
  a_accept_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted word produced no result");

  a_idle_word_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !in_tick) |=> ($stable(pwm_cnt_r) && $stable(pre_cnt_r) &&
                              $stable(stp_cnt_r) && $stable(fade_st)))
    else $error("idle word changed state");

  a_phase_only_on_step: assert property (@(posedge clk) disable iff (!rst_n)
    !fade_ctrl.step |=> $stable(fade_st.phase))
    else $error("fade phase moved without a fade step");

  a_step_needs_base: assert property (@(posedge clk) disable iff (!rst_n)
    fade_ctrl.step |-> (base_wrap && tick_go))
    else $error("fade step without prescaler wrap");
`endif

endmodule

[design/rcp_fade.sv]
// rcp_fade: duty registers and three-phase color cross-fade sequencer.
// Depends on rcp_pkg.
module rcp_fade
  import rcp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  fade_ctrl_t  ctrl,
  output fade_state_t state
);

  logic [DUTY_W-1:0] red_r, red_nxt;
  logic [DUTY_W-1:0] green_r, green_nxt;
  logic [DUTY_W-1:0] blue_r, blue_nxt;
  phase_t            phase_r, phase_nxt;

  logic [DUTY_W-1:0] red_up, green_up, blue_up;
  logic [DUTY_W-1:0] red_dn, green_dn, blue_dn;

  // rising color saturates at max_duty, falling color stops at zero
  always_comb begin
    red_up   = (red_r < ctrl.max_duty) ? DUTY_W'(red_r + 1'b1) : red_r;
    green_up = (green_r < ctrl.max_duty) ? DUTY_W'(green_r + 1'b1) : green_r;
    blue_up  = (blue_r < ctrl.max_duty) ? DUTY_W'(blue_r + 1'b1) : blue_r;
    red_dn   = (red_r != '0) ? DUTY_W'(red_r - 1'b1) : red_r;
    green_dn = (green_r != '0) ? DUTY_W'(green_r - 1'b1) : green_r;
    blue_dn  = (blue_r != '0) ? DUTY_W'(blue_r - 1'b1) : blue_r;
  end

  always_comb begin
    red_nxt   = red_r;
    green_nxt = green_r;
    blue_nxt  = blue_r;
    phase_nxt = phase_r;
    if (ctrl.step) begin
      case (phase_r)
        PH_RED: begin
          red_nxt  = red_up;
          blue_nxt = blue_dn;
          if (red_up >= ctrl.max_duty) phase_nxt = PH_GREEN;
        end
        PH_GREEN: begin
          red_nxt   = red_dn;
          green_nxt = green_up;
          if (green_up >= ctrl.max_duty) phase_nxt = PH_BLUE;
        end
        default: begin
          // blue rising; unused code 3 falls here too
          green_nxt = green_dn;
          blue_nxt  = blue_up;
          if (blue_up >= ctrl.max_duty) phase_nxt = PH_RED;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_r   <= '0;
      green_r <= '0;
      blue_r  <= '0;
      phase_r <= PH_RED;
    end else begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
      phase_r <= phase_nxt;
    end
  end

  assign state.red   = red_r;
  assign state.green = green_r;
  assign state.blue  = blue_r;
  assign state.phase = phase_r;

endmodule

[dv/tb.sv]
// tb: self-checking bench for rgb_crossfade_pwm_top, a PWM and RGB cross-fade block.
// It needs rcp_pkg and the RTL. A built-in fade predictor checks every out word;
// random gaps on both channels; APB register writes happen between drained test segments.
module tb;
  import rcp_pkg::*;

  localparam int CW = COUNT_WIDTH_DEF;

  typedef struct packed {
    logic   red;
    logic   green;
    logic   blue;
    phase_t phase;
  } pin_word_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              in_tick = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              out_red_pin;
  logic              out_green_pin;
  logic              out_blue_pin;
  logic [1:0]        out_fade_phase;
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [APB_AW-1:0] cfg_paddr = '0;
  logic [APB_DW-1:0] cfg_pwdata = '0;
  logic [APB_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  rgb_crossfade_pwm_top #(.COUNT_WIDTH(CW)) uut (.*);

  always #5 clk = ~clk;

  // fade predictor state and its copy of the registers
  logic [REG_W-1:0]  period_reg = PWM_PERIOD_RST;
  logic [REG_W-1:0]  base_reg   = TICKS_PER_BASE_RST;
  logic [REG_W-1:0]  step_reg   = BASES_PER_STEP_RST;
  logic [REG_W-1:0]  max_reg    = MAX_DUTY_RST;
  logic [CW-1:0]     pwm_cnt = '0;
  logic [CW-1:0]     prescale_cnt = '0;
  logic [CW-1:0]     step_cnt = '0;
  logic [DUTY_W-1:0] red_lvl = '0;
  logic [DUTY_W-1:0] green_lvl = '0;
  logic [DUTY_W-1:0] blue_lvl = '0;
  phase_t            fade_ph = PH_RED;
  logic              pin_r = 1'b1;
  logic              pin_g = 1'b1;
  logic              pin_b = 1'b1;

  logic      tick_q[$];
  pin_word_t pin_words_due[$];

  int in_taken = 0, in_sent = 0, in_gap = 0, in_burst = 0;
  int out_taken = 0, out_seen = 0, out_stall = 0, out_burst = 0;
  int errors = 0, fade_steps = 0, phase_turns = 0, settings = 0;

  task automatic fade_once();
    phase_t was;
    was = fade_ph;
    fade_steps++;
    case (fade_ph)
      PH_RED: begin
        if (red_lvl < max_reg) red_lvl++;
        if (red_lvl >= max_reg) fade_ph = PH_GREEN;
        if (blue_lvl != 0) blue_lvl--;
      end
      PH_GREEN: begin
        if (red_lvl != 0) red_lvl--;
        if (green_lvl < max_reg) green_lvl++;
        if (green_lvl >= max_reg) fade_ph = PH_BLUE;
      end
      default: begin
        if (green_lvl != 0) green_lvl--;
        if (blue_lvl < max_reg) blue_lvl++;
        if (blue_lvl >= max_reg) fade_ph = PH_RED;
      end
    endcase
    if (fade_ph != was) phase_turns++;
  endtask

  // advance the predictor by one in word and queue the pin word it yields
  task automatic predict_pins(input logic tick);
    pin_word_t w;
    if (tick) begin
      pwm_cnt = pwm_cnt + 1'b1;
      if (pwm_cnt >= period_reg) pwm_cnt = '0;
      // pins use the duties from before this tick's fade step
      pin_r = !(pwm_cnt < red_lvl);
      pin_g = !(pwm_cnt < green_lvl);
      pin_b = !(pwm_cnt < blue_lvl);
      prescale_cnt = prescale_cnt + 1'b1;
      if (prescale_cnt >= base_reg) begin
        prescale_cnt = '0;
        step_cnt = step_cnt + 1'b1;
        if (step_cnt >= step_reg) begin
          step_cnt = '0;
          fade_once();
        end
      end
    end
    w.red = pin_r;
    w.green = pin_g;
    w.blue = pin_b;
    w.phase = fade_ph;
    pin_words_due.push_back(w);
  endtask

  task automatic flag_mismatch(input string what, input int exp_v, input int act_v);
    errors++;
    if (errors <= 10)
      $display("[%0t] %s: expected %0d, got %0d", $realtime, what, exp_v, act_v);
  endtask

  // handshakes are sampled here, at the rising edge
  always @(posedge clk) begin
    pin_word_t w;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_pins(in_tick);
        in_taken++;
      end
      if (out_valid && out_ready) begin
        out_taken++;
        if (pin_words_due.size() == 0) begin
          flag_mismatch("unexpected out word, phase", -1, int'(out_fade_phase));
        end else begin
          w = pin_words_due.pop_front();
          if (out_red_pin !== w.red)
            flag_mismatch("red_pin", int'(w.red), int'(out_red_pin));
          if (out_green_pin !== w.green)
            flag_mismatch("green_pin", int'(w.green), int'(out_green_pin));
          if (out_blue_pin !== w.blue)
            flag_mismatch("blue_pin", int'(w.blue), int'(out_blue_pin));
          if (out_fade_phase !== w.phase)
            flag_mismatch("fade_phase", int'(w.phase), int'(out_fade_phase));
        end
      end
    end
  end

  always @(negedge clk) begin : tick_driver
    logic nv;
    logic nt;
    nv = in_valid;
    nt = in_tick;
    if (in_taken != in_sent) begin
      in_sent = in_taken;
      nv = 1'b0;
      in_gap = in_burst ? 0 : $urandom_range(0, 4);
      if ($urandom_range(0, 29) == 0) in_burst = !in_burst;
    end
    if (!nv && rst_n && tick_q.size() != 0) begin
      if (in_gap > 0) begin
        in_gap--;
      end else begin
        nt = tick_q.pop_front();
        nv = 1'b1;
      end
    end
    in_valid <= nv;
    in_tick <= nt;
  end

  always @(negedge clk) begin
    if (out_taken != out_seen) begin
      out_seen = out_taken;
      out_stall = out_burst ? 0 : $urandom_range(0, 4);
      if ($urandom_range(0, 29) == 0) out_burst = !out_burst;
    end
    if (out_stall > 0) begin
      out_stall--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= rst_n;
    end
  end

  task automatic apb_write(input reg_idx_t idx, input logic [REG_W-1:0] val);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= APB_DW'(val);
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    case (idx)
      REG_PWM_PERIOD:     period_reg = val;
      REG_TICKS_PER_BASE: base_reg = val;
      REG_BASES_PER_STEP: step_reg = val;
      default:            max_reg = val;
    endcase
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  // block until every queued word has gone through and its result came back
  task automatic wait_drained();
    do @(posedge clk);
    while (tick_q.size() != 0 || in_valid || pin_words_due.size() != 0);
  endtask

  task automatic load_regs(input logic [7:0] pp, input logic [7:0] tpb,
                           input logic [7:0] bps, input logic [7:0] md);
    wait_drained();
    repeat (2) @(posedge clk);
    apb_write(REG_PWM_PERIOD, pp);
    apb_write(REG_TICKS_PER_BASE, tpb);
    apb_write(REG_BASES_PER_STEP, bps);
    apb_write(REG_MAX_DUTY, md);
    settings++;
  endtask

  // n timer ticks with the odd idle word mixed in
  task automatic queue_ticks(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 7) == 0) tick_q.push_back(1'b0);
      tick_q.push_back(1'b1);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: defaults with idle words, all-zero registers, then minimal period
    tick_q = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
    load_regs(8'd0, 8'd0, 8'd0, 8'd0);
    tick_q = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
    load_regs(8'd1, 8'd1, 8'd1, 8'd1);
    tick_q = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};

    // random part: top and bottom of every register, lowered max_duty mid-fade
    load_regs(8'd255, 8'd1, 8'd1, 8'd255);
    queue_ticks(300);
    load_regs(8'd9, 8'd2, 8'd1, 8'd8);
    queue_ticks(100);
    load_regs(8'd3, 8'd1, 8'd1, 8'd200);
    queue_ticks(220);
    load_regs(8'd3, 8'd1, 8'd1, 8'd4);
    queue_ticks(60);
    load_regs(8'd6, 8'd255, 8'd1, 8'd2);
    queue_ticks(200);
    load_regs(8'd12, 8'd1, 8'd255, 8'd3);
    queue_ticks(100);
    repeat (4) begin
      load_regs(8'($urandom_range(0, 16)), 8'($urandom_range(0, 2)),
                8'($urandom_range(0, 2)), 8'($urandom_range(0, 10)));
      queue_ticks(60);
    end

    wait_drained();
    repeat (8) @(posedge clk);
    $display("Checked %0d out words over %0d register settings", out_taken, settings);
    $display("Predictor saw %0d fade steps and %0d phase changes", fade_steps, phase_turns);
    if (errors == 0 && pin_words_due.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
